// ----- rtl/frst_pkg.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly slot tracker package
// Request, response, table entry and compare result types plus the configuration index, request and status codes.
// ----------------------------------------------------------------------------
package frst_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_ACTIVE = 1'd1;

  localparam logic [1:0] REQ_FRAG    = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;

  localparam logic [2:0] STS_ACCEPTED  = 3'd0;
  localparam logic [2:0] STS_COMPLETED = 3'd1;
  localparam logic [2:0] STS_DROPPED   = 3'd2;
  localparam logic [2:0] STS_INVALID   = 3'd3;
  localparam logic [2:0] STS_MISMATCH  = 3'd4;
  localparam logic [2:0] STS_RELEASED  = 3'd5;
  localparam logic [2:0] STS_FLUSHED   = 3'd6;

  localparam logic [15:0] PROTO_ETH = 16'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] src_key;
    logic [31:0] dst_key;
    logic [15:0] conn_id;
    logic [7:0]  frag_num;
    logic [7:0]  frag_total;
    logic [15:0] proto;
    logic [5:0]  release_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [3:0]  write_index;
    logic        overflow_flush;
    logic [31:0] slot_age;
  } rsp_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] conn;
    logic [7:0]  total;
    logic [7:0]  count;
    logic [31:0] age;
  } entry_t;

  typedef struct packed {
    logic       key_eq;
    logic       mismatch;
    logic [7:0] count_next;
    logic       complete;
  } cmp_t;

endpackage

// ----- rtl/frst_cmp.sv -----
// ----------------------------------------------------------------------------
// Slot compare unit
// Compares one table entry against the pending fragment header and forms the
// updated fragment count.
// ----------------------------------------------------------------------------
module frst_cmp (
  input  frst_pkg::entry_t entry_i,
  input  frst_pkg::req_t   req_i,
  output frst_pkg::cmp_t   cmp_o
);
  import frst_pkg::*;

  always_comb begin
    cmp_o.key_eq     = (entry_i.src == req_i.src_key) && (entry_i.dst == req_i.dst_key) &&
                       (entry_i.conn == req_i.conn_id);
    cmp_o.mismatch   = (entry_i.total != req_i.frag_total) ||
                       (entry_i.count > req_i.frag_total);
    cmp_o.count_next = entry_i.count + 8'd1;
    cmp_o.complete   = (cmp_o.count_next == entry_i.total);
  end

endmodule

// ----- rtl/fragment_reassembly_slot_tracker.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly slot tracker
// Tracks packet reassembly slots for incoming fragment headers.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Fragment headers
// are filtered, then the slot table is scanned one entry per cycle through a
// single registered read port of the slot memory and one shared compare unit.
// Release, flush, drop and invalid requests answer from the decode state. A
// fragment that joins slot k answers when the scan reaches slot k; one that
// claims a new slot answers when the scan reaches the last slot. Each request
// yields one response on rsp_o, shown for exactly one cycle with done_o high;
// the receiver cannot hold it off, and a new request may be taken in the
// cycle the response is shown. Request type 3 yields no response. The
// configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while no request is in flight,
// which the block does not enforce. Reset frees all slots, clears the age
// counter and the registers; the slot memory needs no clearing pass because
// per-slot valid bits hold the free state.
// ----------------------------------------------------------------------------
module fragment_reassembly_slot_tracker #(
  parameter int SLOTS     = 64,
  parameter int MAX_FRAGS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [frst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                start_i,
  input  frst_pkg::req_t                      req_i,
  output logic                                busy_o,
  output logic                                done_o,
  output frst_pkg::rsp_t                      rsp_o
);
  import frst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW    = (IDX_W > 6) ? IDX_W : 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_SCAN   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  req_t               req_q;
  logic [31:0]        node_id_q;
  logic               net_active_q;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [31:0]        age_cnt_q, age_cnt_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic               issue_done_q, issue_done_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic               free_found_q, free_found_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [31:0]        age0_q, age0_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;
  entry_t             rd_q;
  entry_t             slot_mem_q [SLOTS];

  logic               rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  cmp_t               cmp;
  logic [RW-1:0]      rel_w;
  logic               rel_in_range;
  logic               drop;
  logic               invalid;
  logic               pend_valid;
  logic               hit;
  logic               last;
  logic               pend_free;
  logic               claim_free;
  logic [IDX_W-1:0]   claim_idx;
  logic [31:0]        age0;

  frst_cmp u_cmp (
    .entry_i (rd_q),
    .req_i   (req_q),
    .cmp_o   (cmp)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign rel_w        = RW'(req_q.release_slot);
  assign rel_in_range = (32'(req_q.release_slot) < 32'(SLOTS));
  assign drop         = (req_q.src_key == node_id_q) ||
                        ((req_q.proto == PROTO_ETH) && !net_active_q);
  assign invalid      = (req_q.frag_total == 8'd0) || (req_q.frag_num >= req_q.frag_total) ||
                        (req_q.frag_num >= 8'(MAX_FRAGS));
  assign pend_valid   = valid_q[pend_idx_q];
  assign hit          = pend_q && pend_valid && cmp.key_eq;
  assign last         = pend_q && (pend_idx_q == LAST_IDX);
  assign pend_free    = pend_q && !pend_valid;
  assign claim_free   = free_found_q || pend_free;
  assign claim_idx    = free_found_q ? free_idx_q : pend_idx_q;
  assign age0         = (pend_idx_q == '0) ? rd_q.age : age0_q;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    age_cnt_d    = age_cnt_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    age0_d       = age0_q;
    done_d       = 1'b0;
    rsp_d        = '0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d      = ST_IDLE;
        addr_d       = '0;
        issue_done_d = 1'b0;
        pend_d       = 1'b0;
        free_found_d = 1'b0;
        unique case (req_q.req_type)
          REQ_RELEASE: begin
            if (rel_in_range) begin
              valid_d[rel_w[IDX_W-1:0]] = 1'b0;
            end
            done_d       = 1'b1;
            rsp_d.status = STS_RELEASED;
            rsp_d.slot   = req_q.release_slot;
          end
          REQ_FLUSH: begin
            valid_d      = '0;
            done_d       = 1'b1;
            rsp_d.status = STS_FLUSHED;
          end
          REQ_FRAG: begin
            if (drop) begin
              done_d       = 1'b1;
              rsp_d.status = STS_DROPPED;
            end else if (invalid) begin
              done_d       = 1'b1;
              rsp_d.status = STS_INVALID;
            end else begin
              state_d = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        pend_d = !issue_done_q;
        if (!issue_done_q) begin
          rd_en      = 1'b1;
          pend_idx_d = addr_q;
          addr_d     = addr_q + 1'b1;
          if (addr_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end
        end
        if (pend_q && (pend_idx_q == '0)) begin
          age0_d = rd_q.age;
        end
        if (hit) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (cmp.mismatch) begin
            rsp_d.status = STS_MISMATCH;
          end else begin
            mem_we              = 1'b1;
            mem_waddr           = pend_idx_q;
            mem_wdata.count     = cmp.count_next;
            rsp_d.status        = cmp.complete ? STS_COMPLETED : STS_ACCEPTED;
            rsp_d.slot          = 6'(pend_idx_q);
            rsp_d.write_index   = req_q.frag_num[3:0];
            rsp_d.slot_age      = rd_q.age;
          end
        end else if (last) begin
          state_d            = ST_IDLE;
          done_d             = 1'b1;
          mem_we             = 1'b1;
          mem_wdata.src      = req_q.src_key;
          mem_wdata.dst      = req_q.dst_key;
          mem_wdata.conn     = req_q.conn_id;
          mem_wdata.total    = req_q.frag_total;
          mem_wdata.count    = 8'd1;
          rsp_d.status       = (req_q.frag_total == 8'd1) ? STS_COMPLETED : STS_ACCEPTED;
          rsp_d.write_index  = req_q.frag_num[3:0];
          if (claim_free) begin
            mem_waddr          = claim_idx;
            mem_wdata.age      = age_cnt_q;
            age_cnt_d          = age_cnt_q + 32'd1;
            valid_d[claim_idx] = 1'b1;
            rsp_d.slot         = 6'(claim_idx);
            rsp_d.slot_age     = age_cnt_q;
          end else begin
            mem_waddr            = '0;
            mem_wdata.age        = age0;
            valid_d              = '0;
            valid_d[0]           = 1'b1;
            rsp_d.overflow_flush = 1'b1;
            rsp_d.slot_age       = age0;
          end
        end else if (pend_free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = pend_idx_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      age_cnt_q    <= '0;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      age0_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      age_cnt_q    <= age_cnt_d;
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      pend_q       <= pend_d;
      pend_idx_q   <= pend_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      age0_q       <= age0_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      net_active_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NODE_ID:    node_id_q    <= cfg_data_i;
        CFG_NET_ACTIVE: net_active_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= slot_mem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_o))
    else $error("response without a request in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_DECODE))
    else $error("taken request did not enter decode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.overflow_flush) |-> ((rsp_o.slot == 6'd0) && (valid_q == SLOTS'(1))))
    else $error("overflow flush did not leave only slot 0 occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((rsp_o.status == STS_ACCEPTED) || (rsp_o.status == STS_COMPLETED)))
    |-> valid_q[rsp_o.slot[IDX_W-1:0]])
    else $error("accepted fragment reported for a free slot");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly slot tracker testbench
// Drives fragment, release, flush and unused-type requests through the command
// port and checks every response field against a behavioral model of the slot
// table or a fixed expected response. A short directed table comes first. Then
// come a table overflow, a long packet that wraps its fragment count, and
// random phases under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import frst_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam int FRAG_LIMIT = 16;
  localparam int POOL = 12;
  localparam int RUN_LIMIT = 600000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    req_t r;
    logic fixed;
    rsp_t rsp;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_NODE_ID;
  logic [31:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  logic req_fixed = 1'b0;
  rsp_t rsp_fixed = '0;

  bit [7:0] slot_total[SLOT_COUNT];
  bit [7:0] slot_count[SLOT_COUNT];
  bit [31:0] slot_src[SLOT_COUNT];
  bit [31:0] slot_dst[SLOT_COUNT];
  bit [15:0] slot_conn[SLOT_COUNT];
  bit [31:0] slot_age[SLOT_COUNT];
  bit [31:0] age_next;
  bit [31:0] node_id_m;
  bit net_active_m;

  rsp_t rsp_expected[$];
  plan_row_t directed[$];

  bit [31:0] pool_src[POOL];
  bit [31:0] pool_dst[POOL];
  bit [15:0] pool_conn[POOL];
  bit [7:0] pool_tot[POOL];

  int n_taken, n_seen, n_complete, n_overflow, n_errors, cycles;

  always #4 clk_i = ~clk_i;

  fragment_reassembly_slot_tracker #(
    .SLOTS(SLOT_COUNT),
    .MAX_FRAGS(FRAG_LIMIT)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .start_i(start_i),
    .req_i(req_i),
    .busy_o(busy_o),
    .done_o(done_o),
    .rsp_o(rsp_o)
  );

  function automatic req_t mk(logic [1:0] kind, logic [31:0] src, logic [31:0] dst,
                              logic [15:0] conn, logic [7:0] num, logic [7:0] tot,
                              logic [15:0] proto, logic [5:0] rel);
    req_t r;
    r.req_type = kind;
    r.src_key = src;
    r.dst_key = dst;
    r.conn_id = conn;
    r.frag_num = num;
    r.frag_total = tot;
    r.proto = proto;
    r.release_slot = rel;
    return r;
  endfunction

  function automatic rsp_t known(logic [2:0] st, logic [5:0] sl);
    rsp_t o;
    o = '0;
    o.status = st;
    o.slot = sl;
    return o;
  endfunction

  function automatic void plan(req_t r, bit fixed, rsp_t want);
    plan_row_t row;
    row.r = r;
    row.fixed = fixed;
    row.rsp = want;
    directed.push_back(row);
  endfunction

  function automatic bit predict_slot_rsp(input req_t r, output rsp_t o);
    int hit;
    int spot;
    bit spilled;
    o = '0;
    hit = -1;
    spot = -1;
    spilled = 1'b0;
    case (r.req_type)
      REQ_RELEASE: begin
        slot_total[r.release_slot] = '0;
        o.status = STS_RELEASED;
        o.slot = r.release_slot;
        return 1'b1;
      end
      REQ_FLUSH: begin
        foreach (slot_total[i]) slot_total[i] = '0;
        o.status = STS_FLUSHED;
        return 1'b1;
      end
      REQ_FRAG: ;
      default: return 1'b0;
    endcase
    if (r.src_key == node_id_m || (r.proto == PROTO_ETH && !net_active_m)) begin
      o.status = STS_DROPPED;
      return 1'b1;
    end
    if (r.frag_total == 0 || r.frag_num >= r.frag_total || r.frag_num >= FRAG_LIMIT) begin
      o.status = STS_INVALID;
      return 1'b1;
    end
    for (int i = 0; i < SLOT_COUNT && hit < 0; i++)
      if (slot_total[i] != 0 && slot_src[i] == r.src_key && slot_dst[i] == r.dst_key &&
          slot_conn[i] == r.conn_id)
        hit = i;
    if (hit >= 0) begin
      if (slot_total[hit] != r.frag_total || slot_count[hit] > r.frag_total) begin
        o.status = STS_MISMATCH;
        return 1'b1;
      end
      spot = hit;
    end else begin
      for (int i = 0; i < SLOT_COUNT && spot < 0; i++)
        if (slot_total[i] == 0) spot = i;
      if (spot < 0) begin
        foreach (slot_total[i]) slot_total[i] = '0;
        spot = 0;
        spilled = 1'b1;
      end else begin
        slot_age[spot] = age_next;
        age_next = age_next + 1;
      end
      slot_total[spot] = r.frag_total;
      slot_src[spot] = r.src_key;
      slot_dst[spot] = r.dst_key;
      slot_conn[spot] = r.conn_id;
      slot_count[spot] = '0;
    end
    slot_count[spot] = slot_count[spot] + 8'd1;
    o.status = (slot_count[spot] == slot_total[spot]) ? STS_COMPLETED : STS_ACCEPTED;
    o.slot = spot[5:0];
    o.write_index = r.frag_num[3:0];
    o.overflow_flush = spilled;
    o.slot_age = slot_age[spot];
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 50)
      $display("cycle %0d: %s is %0h, expected %0h", cycles, what, got, want);
  endtask

  task automatic check_rsp(rsp_t got, rsp_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
    if (got.write_index !== want.write_index)
      report_mismatch("write_index", got.write_index, want.write_index);
    if (got.overflow_flush !== want.overflow_flush)
      report_mismatch("overflow_flush", got.overflow_flush, want.overflow_flush);
    if (got.slot_age !== want.slot_age) report_mismatch("slot_age", got.slot_age, want.slot_age);
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t guess;
    if (rst_ni) begin
      if (done_o) begin
        n_seen++;
        if (rsp_expected.size() == 0) begin
          report_mismatch("unexpected response, status", rsp_o.status, '0);
        end else begin
          want = rsp_expected.pop_front();
          check_rsp(rsp_o, want);
        end
        if (rsp_o.status == STS_COMPLETED) n_complete++;
        if (rsp_o.overflow_flush) n_overflow++;
      end
      if (start_i && !busy_o) begin
        n_taken++;
        if (predict_slot_rsp(req_i, guess)) rsp_expected.push_back(req_fixed ? rsp_fixed : guess);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int pick_gap(bit eager);
    int roll;
    roll = $urandom_range(0, 99);
    if (eager || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 90);
  endfunction

  task automatic issue(input req_t r, input bit fixed, input rsp_t want, input int gap);
    start_i <= 1'b1;
    req_i <= r;
    req_fixed <= fixed;
    rsp_fixed <= want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_expected.size() != 0) @(posedge clk_i);
    repeat (SLOT_COUNT + 8) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] node, logic net);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_NODE_ID;
    cfg_data_i <= node;
    @(posedge clk_i);
    node_id_m = node;
    cfg_idx_i <= CFG_NET_ACTIVE;
    cfg_data_i <= {31'($urandom), net};
    @(posedge clk_i);
    net_active_m = net;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void refresh_pool();
    bit [31:0] s[3];
    bit [31:0] d[3];
    bit [15:0] c[3];
    foreach (s[i]) begin
      s[i] = $urandom;
      d[i] = $urandom;
      c[i] = $urandom;
    end
    foreach (pool_src[k]) begin
      pool_src[k] = s[$urandom_range(0, 2)];
      pool_dst[k] = d[$urandom_range(0, 2)];
      pool_conn[k] = c[$urandom_range(0, 2)];
      pool_tot[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
    end
  endfunction

  function automatic req_t draw_request();
    req_t r;
    int k;
    int lim;
    int roll;
    r = mk(REQ_FRAG, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 99);
    if (roll < 62) begin
      k = $urandom_range(0, POOL - 1);
      lim = (pool_tot[k] > FRAG_LIMIT) ? FRAG_LIMIT : pool_tot[k];
      r.src_key = pool_src[k];
      r.dst_key = pool_dst[k];
      r.conn_id = pool_conn[k];
      r.frag_total = pool_tot[k];
      r.frag_num = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 9) == 0) r.frag_total = $urandom_range(1, 20);
      if ($urandom_range(0, 19) == 0) r.frag_num = $urandom_range(lim, 255);
      if ($urandom_range(0, 7) == 0) r.proto = PROTO_ETH;
    end else if (roll < 70) begin
      r.src_key = node_id_m;
    end else if (roll < 80) begin
      r.req_type = REQ_RELEASE;
      if ($urandom_range(0, 9) < 7) r.release_slot = $urandom_range(0, 15);
    end else if (roll < 83) begin
      r.req_type = REQ_FLUSH;
    end else if (roll < 85) begin
      r.req_type = REQ_UNUSED;
    end else if (roll < 93) begin
      r.frag_num = $urandom_range(0, 31);
    end
    return r;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan(mk(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, known(STS_FLUSHED, 0));
    plan(mk(REQ_RELEASE, 0, 0, 0, 0, 0, 0, 63), 1'b1, known(STS_RELEASED, 63));
    plan(mk(REQ_FRAG, 0, 1, 1, 0, 1, 2, 0), 1'b1, known(STS_DROPPED, 0));
    plan(mk(REQ_FRAG, 1, 1, 1, 0, 1, PROTO_ETH, 0), 1'b1, known(STS_DROPPED, 0));
    plan(mk(REQ_FRAG, 1, 1, 1, 0, 0, 2, 0), 1'b1, known(STS_INVALID, 0));
    plan(mk(REQ_FRAG, 1, 1, 1, 5, 5, 2, 0), 1'b1, known(STS_INVALID, 0));
    plan(mk(REQ_FRAG, 1, 1, 1, 16, 255, 2, 0), 1'b1, known(STS_INVALID, 0));
    plan(mk(REQ_FRAG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 1, 16'hFFFF, 6'h3F), 1'b1,
         known(STS_COMPLETED, 0));
    plan(mk(REQ_FRAG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 1, 16'hFFFF, 6'h3F), 1'b0, '0);
    plan(mk(REQ_FRAG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 1, 16'hFFFF, 6'h3F), 1'b1,
         known(STS_MISMATCH, 0));
    plan(mk(REQ_FRAG, 1, 2, 3, 15, 16, 16'hFFFE, 0), 1'b0, '0);
    plan(mk(REQ_FRAG, 1, 2, 3, 0, 15, 16'hFFFE, 0), 1'b1, known(STS_MISMATCH, 0));
    plan(mk(REQ_FRAG, 1, 2, 4, 1, 2, 0, 0), 1'b0, '0);
    plan(mk(REQ_FRAG, 1, 3, 3, 0, 2, 0, 0), 1'b0, '0);
    plan(mk(REQ_FRAG, 2, 2, 3, 0, 2, 0, 0), 1'b0, '0);
    plan(mk(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 6'h3F),
         1'b0, '0);
    plan(mk(REQ_RELEASE, 0, 0, 0, 0, 0, 0, 1), 1'b1, known(STS_RELEASED, 1));
    plan(mk(REQ_FRAG, 7, 7, 7, 7, 8, 0, 0), 1'b0, '0);
    plan(mk(REQ_FRAG, 1, 2, 3, 14, 16, 16'hFFFE, 0), 1'b0, '0);
    plan(mk(REQ_FRAG, 32'hFFFF_FFFE, 0, 0, 0, 255, 0, 0), 1'b0, '0);
    plan(mk(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, known(STS_FLUSHED, 0));
    plan(mk(REQ_FRAG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 1, 16'hFFFF, 0), 1'b0, '0);
    foreach (directed[i])
      issue(directed[i].r, directed[i].fixed, directed[i].rsp, pick_gap(1'b0));

    // Fill every slot with an open packet, then overflow the table.
    settle();
    configure(32'hFFFF_FFFF, 1'b1);
    issue(mk(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, known(STS_FLUSHED, 0), pick_gap(1'b0));
    for (int i = 0; i <= SLOT_COUNT; i++)
      issue(mk(REQ_FRAG, {8'h3C, 24'(i)}, ~{8'h3C, 24'(i)}, 16'(i), 0, 2, $urandom, $urandom),
            1'b0, '0, pick_gap(1'b0));
    issue(mk(REQ_FRAG, {8'h3C, 24'd1}, ~{8'h3C, 24'd1}, 16'd1, 1, 2, 0, 0), 1'b0, '0,
          pick_gap(1'b0));
    issue(mk(REQ_FRAG, {8'h3C, 24'(SLOT_COUNT)}, ~{8'h3C, 24'(SLOT_COUNT)}, 16'(SLOT_COUNT),
             1, 2, 0, 0), 1'b0, '0, pick_gap(1'b0));

    // One long packet whose fragment count passes its total and wraps.
    settle();
    configure(32'h0, 1'b1);
    issue(mk(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, known(STS_FLUSHED, 0), 0);
    repeat (258)
      issue(mk(REQ_FRAG, 32'hA5A5_0001, 32'h5A5A_0002, 16'h7777, $urandom_range(0, 15), 255,
               $urandom, $urandom), 1'b0, '0, pick_gap($urandom_range(0, 3) != 0));

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: configure(32'h0, 1'b1);
        1: configure(32'hFFFF_FFFF, 1'b0);
        2: configure($urandom, 1'b1);
        3: configure($urandom, 1'b0);
        default: configure(32'hFFFF_FFFF, 1'b1);
      endcase
      refresh_pool();
      repeat (56) issue(draw_request(), 1'b0, '0, pick_gap(p == 2));
    end
    settle();

    $display("Requests taken: %0d, responses checked: %0d.", n_taken, n_seen);
    $display("Completed packets: %0d, table overflows: %0d, field errors: %0d.",
             n_complete, n_overflow, n_errors);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
